// ===== rtl/scfsm_pkg.sv =====
// Package for the subscription connection state machine.
// Holds request and response types, event, state and status codes.
// No dependencies.
package scfsm_pkg;

   // Event codes carried in the cmd field of a request.
   localparam logic [3:0] EV_CHANGED    = 4'd0;
   localparam logic [3:0] EV_RESTORED   = 4'd1;
   localparam logic [3:0] EV_HS_OK      = 4'd2;
   localparam logic [3:0] EV_HS_FAIL    = 4'd3;
   localparam logic [3:0] EV_RX_OK      = 4'd4;
   localparam logic [3:0] EV_RX_FAIL    = 4'd5;
   localparam logic [3:0] EV_DISCONNECT = 4'd6;
   localparam logic [3:0] EV_RECONNECT  = 4'd7;
   localparam logic [3:0] EV_UNSUB_ALL  = 4'd8;

   // Subscription status codes.
   localparam logic [2:0] SS_CONNECTED  = 3'd0;
   localparam logic [2:0] SS_CONN_ERR   = 3'd1;
   localparam logic [2:0] SS_DISCONN    = 3'd2;
   localparam logic [2:0] SS_CHANGED    = 3'd3;
   localparam logic [2:0] SS_DISC_UNEXP = 3'd4;

   // External state codes as reported in next_state.
   localparam logic [2:0] SC_UNSUB   = 3'd0;
   localparam logic [2:0] SC_HS      = 3'd1;
   localparam logic [2:0] SC_HS_FAIL = 3'd2;
   localparam logic [2:0] SC_HS_STOP = 3'd3;
   localparam logic [2:0] SC_RX      = 3'd4;
   localparam logic [2:0] SC_RX_FAIL = 3'd5;
   localparam logic [2:0] SC_RX_STOP = 3'd6;

   // Internal one-hot state encoding.
   typedef enum logic [6:0] {
      ST_UNSUB   = 7'b0000001,
      ST_HS      = 7'b0000010,
      ST_HS_FAIL = 7'b0000100,
      ST_HS_STOP = 7'b0001000,
      ST_RX      = 7'b0010000,
      ST_RX_FAIL = 7'b0100000,
      ST_RX_STOP = 7'b1000000
   } state_type;

   typedef struct packed {
      logic [3:0] cmd;
      logic       subscription_empty;
   } req_type;

   typedef struct packed {
      logic       accepted;
      logic [2:0] next_state;
      logic       emit_status;
      logic       emit_messages;
      logic [2:0] subscription_status;
      logic       keep_context;
   } rsp_type;

   // Maps the one-hot state onto the external 3-bit state code.
   function automatic logic [2:0] state_code(input state_type st);
      logic [2:0] code;
      begin
         case (st)
            ST_UNSUB:   code = SC_UNSUB;
            ST_HS:      code = SC_HS;
            ST_HS_FAIL: code = SC_HS_FAIL;
            ST_HS_STOP: code = SC_HS_STOP;
            ST_RX:      code = SC_RX;
            ST_RX_FAIL: code = SC_RX_FAIL;
            ST_RX_STOP: code = SC_RX_STOP;
            default:    code = SC_UNSUB;
         endcase
         return code;
      end
   endfunction

endpackage

// ===== rtl/scfsm_step.sv =====
// Transition decode of the subscription connection state machine.
// Purely combinational: current state, stored status and one request in, next values out.
// Depends on scfsm_pkg.
module scfsm_step (
   input  scfsm_pkg::state_type cur_state,
   input  logic [2:0]           cur_status,
   input  scfsm_pkg::req_type   req,
   output scfsm_pkg::state_type nxt_state,
   output logic [2:0]           nxt_status,
   output scfsm_pkg::rsp_type   rsp
);

   logic                 acc;
   logic                 emit_st;
   logic                 emit_msg;
   logic                 upd;
   logic [2:0]           new_st;
   logic                 sub_ev;
   logic                 empty;
   scfsm_pkg::state_type nxt;

   assign sub_ev = (req.cmd == scfsm_pkg::EV_CHANGED) || (req.cmd == scfsm_pkg::EV_RESTORED);
   assign empty  = req.subscription_empty;

   always_comb begin
      acc      = 1'b0;
      nxt      = cur_state;
      emit_st  = 1'b0;
      emit_msg = 1'b0;
      upd      = 1'b0;
      new_st   = scfsm_pkg::SS_CONNECTED;
      case (cur_state)
         scfsm_pkg::ST_UNSUB: begin
            if (sub_ev) begin
               acc = 1'b1;
               nxt = scfsm_pkg::ST_HS;
            end
         end
         scfsm_pkg::ST_HS: begin
            if (req.cmd == scfsm_pkg::EV_CHANGED) begin
               acc = 1'b1;
               nxt = empty ? scfsm_pkg::ST_UNSUB : scfsm_pkg::ST_HS;
            end else if (req.cmd == scfsm_pkg::EV_RESTORED) begin
               acc = 1'b1;
            end else if (req.cmd == scfsm_pkg::EV_HS_OK) begin
               acc     = 1'b1;
               nxt     = scfsm_pkg::ST_RX;
               emit_st = 1'b1;
               upd     = 1'b1;
               new_st  = scfsm_pkg::SS_CONNECTED;
            end else if (req.cmd == scfsm_pkg::EV_HS_FAIL) begin
               acc     = 1'b1;
               nxt     = scfsm_pkg::ST_HS_FAIL;
               emit_st = 1'b1;
               upd     = 1'b1;
               new_st  = scfsm_pkg::SS_CONN_ERR;
            end else if (req.cmd == scfsm_pkg::EV_DISCONNECT) begin
               acc = 1'b1;
               nxt = scfsm_pkg::ST_HS_STOP;
            end else if (req.cmd == scfsm_pkg::EV_UNSUB_ALL) begin
               acc = 1'b1;
               nxt = scfsm_pkg::ST_UNSUB;
            end
         end
         scfsm_pkg::ST_HS_FAIL: begin
            if (sub_ev) begin
               acc = 1'b1;
               nxt = empty ? scfsm_pkg::ST_UNSUB : scfsm_pkg::ST_HS;
            end else if (req.cmd == scfsm_pkg::EV_RECONNECT) begin
               acc = 1'b1;
               nxt = scfsm_pkg::ST_HS;
            end else if (req.cmd == scfsm_pkg::EV_UNSUB_ALL) begin
               acc = 1'b1;
               nxt = scfsm_pkg::ST_UNSUB;
            end
         end
         scfsm_pkg::ST_HS_STOP, scfsm_pkg::ST_RX_STOP: begin
            // Subscription edits while stopped are absorbed in place.
            if (sub_ev) begin
               acc = 1'b1;
            end else if (req.cmd == scfsm_pkg::EV_RECONNECT) begin
               acc = 1'b1;
               nxt = scfsm_pkg::ST_HS;
            end else if (req.cmd == scfsm_pkg::EV_UNSUB_ALL) begin
               acc = 1'b1;
               nxt = scfsm_pkg::ST_UNSUB;
            end
         end
         scfsm_pkg::ST_RX: begin
            if (sub_ev) begin
               acc     = 1'b1;
               emit_st = 1'b1;
               upd     = 1'b1;
               if (empty) begin
                  nxt    = scfsm_pkg::ST_UNSUB;
                  new_st = scfsm_pkg::SS_DISCONN;
               end else begin
                  new_st = scfsm_pkg::SS_CHANGED;
               end
            end else if (req.cmd == scfsm_pkg::EV_RX_OK) begin
               acc      = 1'b1;
               emit_msg = 1'b1;
            end else if (req.cmd == scfsm_pkg::EV_RX_FAIL) begin
               acc     = 1'b1;
               nxt     = scfsm_pkg::ST_RX_FAIL;
               emit_st = 1'b1;
               upd     = 1'b1;
               new_st  = scfsm_pkg::SS_DISC_UNEXP;
            end else if (req.cmd == scfsm_pkg::EV_DISCONNECT) begin
               acc     = 1'b1;
               nxt     = scfsm_pkg::ST_RX_STOP;
               emit_st = 1'b1;
               upd     = 1'b1;
               new_st  = scfsm_pkg::SS_DISCONN;
            end else if (req.cmd == scfsm_pkg::EV_UNSUB_ALL) begin
               acc     = 1'b1;
               nxt     = scfsm_pkg::ST_UNSUB;
               emit_st = 1'b1;
               upd     = 1'b1;
               new_st  = scfsm_pkg::SS_DISCONN;
            end
         end
         scfsm_pkg::ST_RX_FAIL: begin
            if (sub_ev || (req.cmd == scfsm_pkg::EV_RECONNECT)) begin
               acc = 1'b1;
               nxt = scfsm_pkg::ST_HS;
            end else if (req.cmd == scfsm_pkg::EV_UNSUB_ALL) begin
               acc = 1'b1;
               nxt = scfsm_pkg::ST_UNSUB;
            end
         end
         default: begin
            acc = 1'b0;
         end
      endcase
   end

   assign nxt_state  = nxt;
   assign nxt_status = upd ? new_st : cur_status;

   always_comb begin
      rsp.accepted            = acc;
      rsp.next_state          = scfsm_pkg::state_code(nxt);
      rsp.emit_status         = emit_st;
      rsp.emit_messages       = emit_msg;
      rsp.subscription_status = nxt_status;
      rsp.keep_context        = acc && (nxt != scfsm_pkg::ST_UNSUB);
   end

endmodule

// ===== rtl/subscribe_connection_fsm.sv =====
// Top level of the subscription connection state machine.
// Holds the state and status registers and a two-entry response buffer.
// Depends on scfsm_pkg and scfsm_step.

// Subscription connection state machine. Each request carries one event code and a flag
// that says whether the channel and channel group lists are both empty; the block answers
// every request with exactly one response holding the accepted flag, the resulting state,
// the status and message emission flags, the latest subscription status and the keep
// context flag. Events the current state does not handle return accepted low and change
// nothing. A request is taken in every cycle in which req_ready is high; its response is
// registered in the out register, which drives rsp, or, if that is still full after the
// drain, in the skid register behind it. The skid register absorbs one response while the
// consumer stalls, so req_ready drops only when both response registers are full. After
// reset the machine is unsubscribed and the stored status reads disconnected.
module subscribe_connection_fsm (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  scfsm_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output scfsm_pkg::rsp_type rsp_data
);

   scfsm_pkg::state_type state_ff;
   scfsm_pkg::state_type state_in;
   logic [2:0]           status_ff;
   logic [2:0]           status_in;

   scfsm_pkg::state_type step_state;
   logic [2:0]           step_status;
   scfsm_pkg::rsp_type   step_rsp;

   // Response buffer: out is the head shown on rsp, skid holds the one behind it.
   scfsm_pkg::rsp_type out_ff;
   scfsm_pkg::rsp_type out_in;
   logic               out_valid_ff;
   logic               out_valid_in;
   scfsm_pkg::rsp_type skid_ff;
   scfsm_pkg::rsp_type skid_in;
   logic               skid_valid_ff;
   logic               skid_valid_in;

   logic req_fire;
   logic rsp_fire;

   scfsm_step u_step (
      .cur_state  (state_ff),
      .cur_status (status_ff),
      .req        (req_data),
      .nxt_state  (step_state),
      .nxt_status (step_status),
      .rsp        (step_rsp)
   );

   assign req_ready = !skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = out_valid_ff && rsp_ready;

   // The machine advances only on an accepted request.
   always_comb begin
      state_in  = req_fire ? step_state : state_ff;
      status_in = req_fire ? step_status : status_ff;
   end

   // Drain first, then place a new response in the first free slot so order is kept.
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_fire) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (req_fire) begin
         if (!out_valid_in) begin
            out_in       = step_rsp;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = step_rsp;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= scfsm_pkg::ST_UNSUB;
         status_ff     <= scfsm_pkg::SS_DISCONN;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         status_ff     <= status_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Response payload registers need no reset; valid flags guard them.
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule
